FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property checked at every rising clock edge.
`define DBFF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DBFF_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: rtl/core/dbff_pkg.sv
// ----------------------------------------------------------------------------
// Allocator package
// Request codes, status codes, controller states and the map port type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dbff_pkg;

   localparam int WORD_BITS = 64;
   localparam int MAX_ADDR_BITS = 6;

   localparam logic [1:0] KIND_FIND_INODE = 2'd0;
   localparam logic [1:0] KIND_FIND_DATA  = 2'd1;
   localparam logic [1:0] KIND_MARK_BOTH  = 2'd2;
   localparam logic [1:0] KIND_MARK_DATA  = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MARK_RD,
      ST_MARK_WR,
      ST_DONE
   } state_type;

   // One access to a map memory: the read always happens at addr.
   typedef struct packed {
      logic                     wr_en;
      logic [MAX_ADDR_BITS-1:0] addr;
      logic [WORD_BITS-1:0]     wr_data;
   } map_cmd_type;

   // Bit 6 flags a hit, bits 5:0 give the lowest clear bit position.
   function automatic logic [6:0] find_first_zero(input logic [WORD_BITS-1:0] w);
      logic [6:0] r;
      r = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!w[i]) begin
            r = {1'b1, 6'(i)};
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/dual_bitmap_first_free_allocator.sv
// ----------------------------------------------------------------------------
// Dual bitmap first-free allocator
// Inode and data node bitmaps with find-first-clear and mark-used requests.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the req_ stream. tuser carries the request kind (find
// free inode, find free data node, mark both, mark data node); tdata carries
// the inode index and the data node number. Each request gives one word on
// the rsp_ stream: the found index in tdata and a status in tuser.
// The data node base is written on the csr_ channel, always ready. The user
// must write it only while the block is idle; the block does not enforce this.
// A find reads one 64-bit map word per cycle from the map memory and stops at
// the first word with a clear bit. It checks at most MAP_BYTES/8 words, rounded
// up, and never more than 64. A mark does a read-modify-write of one
// word in the data map, and for mark both also in the inode map; a rejected
// request skips the map access. The next request can be taken in the same
// cycle as the response appears. One request is in work at a time. The result
// sits in an output register, so the next request is taken while a result
// waits; a stalled receiver holds the block after that.
// Reset empties both maps except entry zero and clears the base.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dual_bitmap_first_free_allocator
   import dbff_pkg::*;
#(
   parameter int MAP_BYTES = 512
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // [11:0] inode_index, [24:12] data_node_number
   input  wire logic [1:0]  req_tuser,  // [1:0] kind
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,  // [11:0] free_index
   output logic [1:0]       rsp_tuser,  // [1:0] status
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [12:0] csr_data    // [12:0] data_node_base
);

   localparam int MAP_BITS = (MAP_BYTES * 8 < 4096) ? MAP_BYTES * 8 : 4096;
   localparam int DEPTH    = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;

   logic [12:0]          base_ff;
   map_cmd_type          inode_cmd;
   map_cmd_type          data_cmd;
   logic [WORD_BITS-1:0] inode_rd;
   logic [WORD_BITS-1:0] data_rd;
   logic [11:0]          free_index;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else if (csr_valid) begin
         base_ff <= csr_data;
      end
   end

   dbff_map_ram #(
      .DEPTH (DEPTH)
   ) u_inode_map (
      .clock   (clock),
      .reset   (reset),
      .cmd     (inode_cmd),
      .rd_data (inode_rd)
   );

   dbff_map_ram #(
      .DEPTH (DEPTH)
   ) u_data_map (
      .clock   (clock),
      .reset   (reset),
      .cmd     (data_cmd),
      .rd_data (data_rd)
   );

   dbff_ctrl #(
      .DEPTH    (DEPTH),
      .MAP_BITS (MAP_BITS)
   ) u_ctrl (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_tvalid),
      .req_ready            (req_tready),
      .req_kind             (req_tuser),
      .req_inode_index      (req_tdata[11:0]),
      .req_data_node_number (req_tdata[24:12]),
      .data_node_base       (base_ff),
      .inode_cmd            (inode_cmd),
      .data_cmd             (data_cmd),
      .inode_rd             (inode_rd),
      .data_rd              (data_rd),
      .rsp_valid            (rsp_tvalid),
      .rsp_ready            (rsp_tready),
      .rsp_free_index       (free_index),
      .rsp_status           (rsp_tuser)
   );

   assign rsp_tdata = {4'b0000, free_index};

endmodule

`default_nettype wire

FILE: rtl/core/dbff_map_ram.sv
// ----------------------------------------------------------------------------
// Map memory
// One bitmap as a word memory with registered read and per-word valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dbff_map_ram
   import dbff_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire map_cmd_type          cmd,
   output logic [WORD_BITS-1:0]      rd_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WORD_BITS-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0]     valid_ff;
   logic [WORD_BITS-1:0] rd_word_ff;
   logic                 rd_valid_ff;
   logic                 rd_first_ff;
   logic [AW-1:0]        addr;

   assign addr = cmd.addr[AW-1:0];

   // A word never written reads as its reset value: entry zero is used.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.wr_en) begin
         valid_ff[addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[addr] <= cmd.wr_data;
      end
      rd_word_ff  <= mem_ff[addr];
      rd_valid_ff <= valid_ff[addr];
      rd_first_ff <= (addr == '0);
   end

   always_comb begin
      if (rd_valid_ff) begin
         rd_data = rd_word_ff;
      end else if (rd_first_ff) begin
         rd_data = WORD_BITS'(1);
      end else begin
         rd_data = '0;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/dbff_ctrl.sv
// ----------------------------------------------------------------------------
// Allocator controller
// Range checks, word scan, read-modify-write marking and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dbff_ctrl
   import dbff_pkg::*;
#(
   parameter int DEPTH    = 64,
   parameter int MAP_BITS = 4096
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [1:0]           req_kind,
   input  wire logic [11:0]          req_inode_index,
   input  wire logic [12:0]          req_data_node_number,
   input  wire logic [12:0]          data_node_base,
   output map_cmd_type               inode_cmd,
   output map_cmd_type               data_cmd,
   input  wire logic [WORD_BITS-1:0] inode_rd,
   input  wire logic [WORD_BITS-1:0] data_rd,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [11:0]               rsp_free_index,
   output logic [1:0]                rsp_status
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int LAST_BITS = MAP_BITS - (DEPTH - 1) * WORD_BITS;
   localparam logic [WORD_BITS-1:0] LAST_MASK = (LAST_BITS >= WORD_BITS) ?
      {WORD_BITS{1'b1}} : ((WORD_BITS'(1) << LAST_BITS) - WORD_BITS'(1));
   localparam logic [12:0] LIMIT = 13'(MAP_BITS);
   localparam logic [AW-1:0] LAST_WORD = AW'(DEPTH - 1);

   state_type     state_ff, state_in;
   logic [1:0]    kind_ff, kind_in;
   logic [5:0]    ino_word_ff, ino_word_in;
   logic [5:0]    ino_bit_ff, ino_bit_in;
   logic [5:0]    dat_word_ff, dat_word_in;
   logic [5:0]    dat_bit_ff, dat_bit_in;
   logic [CW-1:0] issue_ff, issue_in;
   logic          chk_valid_ff, chk_valid_in;
   logic [AW-1:0] chk_addr_ff, chk_addr_in;
   logic [11:0]   res_index_ff, res_index_in;
   logic [1:0]    res_status_ff, res_status_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [11:0]   rsp_index_ff, rsp_index_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;

   logic [12:0]          doff;
   logic                 bad;
   logic [WORD_BITS-1:0] scan_word;
   logic [6:0]           hit;

   assign doff = req_data_node_number - data_node_base;
   assign bad  = (req_data_node_number < data_node_base) || (doff >= LIMIT) ||
                 ((req_kind == KIND_MARK_BOTH) && ({1'b0, req_inode_index} >= LIMIT));

   // Bits past the end of the map count as used in the last word.
   always_comb begin
      scan_word = (kind_ff == KIND_FIND_INODE) ? inode_rd : data_rd;
      if (chk_addr_ff == LAST_WORD) begin
         scan_word = scan_word | ~LAST_MASK;
      end
   end

   assign hit = find_first_zero(scan_word);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      ino_word_ff   <= ino_word_in;
      ino_bit_ff    <= ino_bit_in;
      dat_word_ff   <= dat_word_in;
      dat_bit_ff    <= dat_bit_in;
      issue_ff      <= issue_in;
      chk_addr_ff   <= chk_addr_in;
      res_index_ff  <= res_index_in;
      res_status_ff <= res_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      ino_word_in   = ino_word_ff;
      ino_bit_in    = ino_bit_ff;
      dat_word_in   = dat_word_ff;
      dat_bit_in    = dat_bit_ff;
      issue_in      = issue_ff;
      chk_valid_in  = chk_valid_ff;
      chk_addr_in   = chk_addr_ff;
      res_index_in  = res_index_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_index_in  = rsp_index_ff;
      rsp_status_in = rsp_status_ff;
      req_ready     = 1'b0;

      inode_cmd.wr_en   = 1'b0;
      inode_cmd.addr    = MAX_ADDR_BITS'(issue_ff[AW-1:0]);
      inode_cmd.wr_data = inode_rd | (WORD_BITS'(1) << ino_bit_ff);
      data_cmd.wr_en    = 1'b0;
      data_cmd.addr     = MAX_ADDR_BITS'(issue_ff[AW-1:0]);
      data_cmd.wr_data  = data_rd | (WORD_BITS'(1) << dat_bit_ff);

      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            kind_in     = req_kind;
            ino_word_in = req_inode_index[11:6];
            ino_bit_in  = req_inode_index[5:0];
            dat_word_in = doff[11:6];
            dat_bit_in  = doff[5:0];
            issue_in    = '0;
            if (req_valid) begin
               chk_valid_in = 1'b0;
               res_index_in = '0;
               if (req_kind == KIND_FIND_INODE || req_kind == KIND_FIND_DATA) begin
                  state_in = ST_SCAN;
               end else if (bad) begin
                  res_status_in = STATUS_RANGE;
                  state_in      = ST_DONE;
               end else begin
                  state_in = ST_MARK_RD;
               end
            end
         end
         ST_SCAN: begin
            // One word is read per cycle; the word read last cycle is checked now.
            if (chk_valid_ff && hit[6]) begin
               res_index_in  = 12'({chk_addr_ff, hit[5:0]});
               res_status_in = STATUS_OK;
               state_in      = ST_DONE;
            end else if (chk_valid_ff && chk_addr_ff == LAST_WORD) begin
               res_index_in  = '0;
               res_status_in = STATUS_FULL;
               state_in      = ST_DONE;
            end else begin
               chk_valid_in = 1'b1;
               chk_addr_in  = issue_ff[AW-1:0];
               issue_in     = issue_ff + CW'(1);
            end
         end
         ST_MARK_RD: begin
            inode_cmd.addr = ino_word_ff;
            data_cmd.addr  = dat_word_ff;
            state_in       = ST_MARK_WR;
         end
         ST_MARK_WR: begin
            inode_cmd.addr  = ino_word_ff;
            data_cmd.addr   = dat_word_ff;
            inode_cmd.wr_en = (kind_ff == KIND_MARK_BOTH);
            data_cmd.wr_en  = 1'b1;
            res_status_in   = STATUS_OK;
            state_in        = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = res_index_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_free_index = rsp_index_ff;
   assign rsp_status     = rsp_status_ff;

   `DBFF_ASSERT(a_write_in_mark, clock, reset, (inode_cmd.wr_en || data_cmd.wr_en) |-> (state_ff == ST_MARK_WR), "map written outside the mark write state")
   `DBFF_ASSERT(a_scan_bound, clock, reset, chk_valid_ff |-> (chk_addr_ff <= LAST_WORD), "scan passed the last map word")
   `DBFF_ASSERT(a_fail_index_zero, clock, reset, (state_ff == ST_DONE && res_status_ff != STATUS_OK) |-> (res_index_ff == '0), "failed request carries a nonzero index")
   `DBFF_ASSERT_NEXT(a_result_loaded, clock, reset, state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready), rsp_valid_ff && state_ff == ST_IDLE, "finished result not presented")

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// Allocator testbench
// Drives find and mark requests into the dual bitmap allocator, keeps its own
// copy of both maps and the data node base, and checks every response word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import dbff_pkg::*;

   localparam int MAP_BYTES = 512;
   localparam int MAP_BITS = (MAP_BYTES * 8 < 4096) ? MAP_BYTES * 8 : 4096;
   localparam int DRAIN_CYCLES = 80;

   typedef struct packed {
      logic [11:0] free_index;
      logic [1:0]  status;
   } alloc_result_type;

   // One row of the directed table: either a base write or a request.
   typedef struct packed {
      logic        is_base_write;
      logic [1:0]  kind;
      logic [11:0] inode_index;
      logic [12:0] node_number;
      logic        typed;
      logic [11:0] exp_index;
      logic [1:0]  exp_status;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;  // [11:0] inode_index, [24:12] data_node_number
   logic [1:0]  req_tuser = '0;  // [1:0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;       // [11:0] free_index
   logic [1:0]  rsp_tuser;       // [1:0] status
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [12:0] csr_data = '0;   // [12:0] data_node_base

   bit [MAP_BITS-1:0] inode_used;
   bit [MAP_BITS-1:0] data_used;
   bit [12:0]         node_base;
   alloc_result_type  pending_results[$];
   alloc_result_type  oldest;
   int                mismatch_count = 0;
   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;

   stim_row_type directed_rows [23] = '{
      '{1'b0, KIND_FIND_INODE, 12'd0,    13'd0,    1'b1, 12'd1, STATUS_OK},
      '{1'b0, KIND_FIND_DATA,  12'd0,    13'd0,    1'b1, 12'd1, STATUS_OK},
      '{1'b0, KIND_MARK_BOTH,  12'd1,    13'd1,    1'b1, 12'd0, STATUS_OK},
      '{1'b0, KIND_FIND_INODE, 12'd0,    13'd0,    1'b1, 12'd2, STATUS_OK},
      '{1'b0, KIND_FIND_DATA,  12'd0,    13'd0,    1'b1, 12'd2, STATUS_OK},
      '{1'b0, KIND_MARK_BOTH,  12'd4095, 13'd4095, 1'b1, 12'd0, STATUS_OK},
      '{1'b0, KIND_MARK_DATA,  12'd0,    13'd4096, 1'b1, 12'd0, STATUS_RANGE},
      '{1'b0, KIND_MARK_DATA,  12'd0,    13'd8191, 1'b1, 12'd0, STATUS_RANGE},
      '{1'b0, KIND_MARK_BOTH,  12'd2,    13'd8191, 1'b1, 12'd0, STATUS_RANGE},
      '{1'b0, KIND_FIND_INODE, 12'd0,    13'd0,    1'b1, 12'd2, STATUS_OK},
      '{1'b0, KIND_MARK_BOTH,  12'd0,    13'd0,    1'b1, 12'd0, STATUS_OK},
      '{1'b0, KIND_MARK_DATA,  12'd4095, 13'd2,    1'b1, 12'd0, STATUS_OK},
      '{1'b0, KIND_FIND_DATA,  12'd0,    13'd0,    1'b0, 12'd0, STATUS_OK},
      '{1'b0, KIND_FIND_INODE, 12'd4095, 13'd8191, 1'b1, 12'd2, STATUS_OK},
      '{1'b0, KIND_MARK_DATA,  12'd0,    13'd0,    1'b1, 12'd0, STATUS_OK},
      '{1'b1, KIND_FIND_INODE, 12'd0,    13'd4096, 1'b0, 12'd0, STATUS_OK},
      '{1'b0, KIND_MARK_DATA,  12'd0,    13'd4095, 1'b1, 12'd0, STATUS_RANGE},
      '{1'b0, KIND_MARK_DATA,  12'd0,    13'd4096, 1'b1, 12'd0, STATUS_OK},
      '{1'b0, KIND_MARK_DATA,  12'd0,    13'd8191, 1'b1, 12'd0, STATUS_OK},
      '{1'b0, KIND_MARK_BOTH,  12'd3,    13'd4099, 1'b1, 12'd0, STATUS_OK},
      '{1'b0, KIND_FIND_DATA,  12'd0,    13'd0,    1'b0, 12'd0, STATUS_OK},
      '{1'b0, KIND_FIND_INODE, 12'd0,    13'd0,    1'b0, 12'd0, STATUS_OK},
      '{1'b1, KIND_FIND_INODE, 12'd0,    13'd0,    1'b0, 12'd0, STATUS_OK}
   };

   dual_bitmap_first_free_allocator #(
      .MAP_BYTES(MAP_BYTES)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Lowest clear bit of a map, or -1 when the addressable range is full.
   function automatic int lowest_free(input bit [MAP_BITS-1:0] map_bits);
      for (int n = 0; n < MAP_BITS; n++) begin
         if (!map_bits[n]) begin
            return n;
         end
      end
      return -1;
   endfunction

   // Works out the response to one accepted request and sets the bits it marks.
   task automatic apply_request(input logic [1:0] kind, input logic [11:0] ino,
                                input logic [12:0] dnum, output alloc_result_type res);
      int  found;
      int  offset;
      bit  in_range;
      res = '{12'd0, STATUS_OK};
      if (kind == KIND_FIND_INODE || kind == KIND_FIND_DATA) begin
         found = (kind == KIND_FIND_INODE) ? lowest_free(inode_used) : lowest_free(data_used);
         if (found < 0) begin
            res.status = STATUS_FULL;
         end else begin
            res.free_index = found[11:0];
         end
      end else begin
         offset = int'(dnum) - int'(node_base);
         in_range = (offset >= 0) && (offset < MAP_BITS);
         if (kind == KIND_MARK_BOTH && int'(ino) >= MAP_BITS) begin
            in_range = 1'b0;
         end
         if (!in_range) begin
            res.status = STATUS_RANGE;
         end else begin
            if (kind == KIND_MARK_BOTH) begin
               inode_used[ino] = 1'b1;
            end
            data_used[offset] = 1'b1;
         end
      end
   endtask

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: %s", $realtime, msg);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("response word with nothing pending: index %0d status %0d",
                                      rsp_tdata[11:0], rsp_tuser));
         end else begin
            oldest = pending_results.pop_front();
            if (rsp_tdata[11:0] !== oldest.free_index || rsp_tuser !== oldest.status) begin
               report_mismatch($sformatf("expected index %0d status %0d, got %0d status %0d",
                                         oldest.free_index, oldest.status,
                                         rsp_tdata[11:0], rsp_tuser));
            end
         end
      end
   end

   // Sends one request word. The valid stays high after acceptance so that a
   // back-to-back word needs no second assignment in the same step.
   task automatic send_request(input logic [1:0] kind, input logic [11:0] ino,
                               input logic [12:0] dnum, input bit typed = 1'b0,
                               input alloc_result_type typed_res = '0);
      alloc_result_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {7'd0, dnum, ino};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      apply_request(kind, ino, dnum, res);
      pending_results.push_back(typed ? typed_res : res);
   endtask

   task automatic wait_for_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_base(input logic [12:0] value);
      wait_for_idle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      node_base = value;
   endtask

   // Data node number near the base, so that most marks land in range.
   function automatic logic [12:0] number_near_base();
      int num;
      num = int'(node_base) + $urandom_range(MAP_BITS - 1);
      return (num > 8191) ? 13'($urandom_range(8191)) : 13'(num);
   endfunction

   task automatic run_random_items(input int count);
      int r;
      int free_ino;
      int free_data;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         free_ino = lowest_free(inode_used);
         free_data = lowest_free(data_used);
         if (r < 30 && free_ino >= 0 && free_data >= 0) begin
            // Allocation: look up the free inode, then claim it with a data node.
            send_request(KIND_FIND_INODE, 12'($urandom_range(4095)), 13'($urandom_range(8191)));
            send_request(KIND_MARK_BOTH, 12'(free_ino), 13'(int'(node_base) + free_data));
         end else if (r < 45 && free_data >= 0) begin
            send_request(KIND_FIND_DATA, 12'($urandom_range(4095)), 13'($urandom_range(8191)));
            send_request(KIND_MARK_DATA, 12'($urandom_range(4095)),
                         13'(int'(node_base) + free_data));
         end else if (r < 75) begin
            send_request($urandom_range(1) ? KIND_MARK_BOTH : KIND_MARK_DATA,
                         12'($urandom_range(4095)),
                         $urandom_range(1) ? number_near_base() : 13'($urandom_range(8191)));
         end else begin
            send_request($urandom_range(1) ? KIND_FIND_INODE : KIND_FIND_DATA,
                         12'($urandom_range(4095)), 13'($urandom_range(8191)));
         end
      end
   endtask

   initial begin
      inode_used = '0;
      data_used = '0;
      inode_used[0] = 1'b1;
      data_used[0] = 1'b1;
      node_base = '0;
      send_idle_pct = 26;
      recv_idle_pct = 51;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_base_write) begin
            write_base(directed_rows[i].node_number);
         end else begin
            send_request(directed_rows[i].kind, directed_rows[i].inode_index,
                         directed_rows[i].node_number, directed_rows[i].typed,
                         '{directed_rows[i].exp_index, directed_rows[i].exp_status});
         end
      end

      write_base(13'd4096);
      run_random_items(135);

      write_base(13'($urandom_range(1, 4095)));
      send_idle_pct = 51;
      recv_idle_pct = 26;
      run_random_items(135);

      write_base(13'd0);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random_items(135);

      wait_for_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #12_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/dbff_pkg.sv
rtl/core/dbff_map_ram.sv
rtl/core/dbff_ctrl.sv
rtl/core/dual_bitmap_first_free_allocator.sv
dv/tb_top.sv
